### design/srhm_pkg.sv
package srhm_pkg;

   localparam int DEFAULT_HISTORY_DEPTH = 256;
   localparam int STAMP_WIDTH           = 64;
   localparam int TIME_WIDTH            = 63;
   localparam int ENTRY_WIDTH           = STAMP_WIDTH + TIME_WIDTH;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

endpackage

### design/srhm_ram.sv
module srhm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/stamp_receipt_history_match_unit.sv
// Ring history of (stamp, receipt time) pairs with a newest-first lookup. An add word
// (command 0) is written at the write pointer in the cycle it is accepted and gives no
// result; the block is ready again the next cycle. A lookup word (command 1) reads the
// history through the single read port of the entry RAM, one entry per cycle from the
// newest back to the oldest written, and stops at the first entry whose stamp equals the
// key and whose receipt time is not later than the query time. The number of entries
// examined is at most the number of entries written, capped at HISTORY_DEPTH. The
// result is held in an output register until taken, and no new word is accepted while
// a lookup is in progress or its result waits. No clearing pass is needed after reset:
// a fill count marks which entries hold data.
module stamp_receipt_history_match_unit #(
   parameter int HISTORY_DEPTH = srhm_pkg::DEFAULT_HISTORY_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic signed [srhm_pkg::STAMP_WIDTH-1:0] req_stamp,
   input  logic [srhm_pkg::TIME_WIDTH-1:0]      req_receipt_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic [srhm_pkg::TIME_WIDTH-1:0]      rsp_delay
);
   import srhm_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(HISTORY_DEPTH);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      RESP
   } state_type;

   state_type               state_ff, state_in;
   logic [AW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]           fill_ff, fill_in;
   logic [AW-1:0]           rd_addr_ff, rd_addr_in;
   logic [CW-1:0]           left_ff, left_in;
   logic                    pend_ff, pend_in;
   logic [STAMP_WIDTH-1:0]  key_ff, key_in;
   logic [TIME_WIDTH-1:0]   when_ff, when_in;
   logic                    found_ff, found_in;
   logic [TIME_WIDTH-1:0]   delay_ff, delay_in;

   logic                    accept;
   logic                    wr_en;
   logic                    rd_en;
   logic [ENTRY_WIDTH-1:0]  rd_data;
   logic [STAMP_WIDTH-1:0]  ent_stamp;
   logic [TIME_WIDTH-1:0]   ent_time;
   logic [TIME_WIDTH:0]     diff;
   logic                    hit;

   assign accept = req_valid && req_ready;
   assign wr_en  = accept && (req_command == CMD_ADD);
   assign rd_en  = (state_ff == SCAN) && (left_ff != '0);

   srhm_ram #(
      .WIDTH(ENTRY_WIDTH),
      .DEPTH(HISTORY_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_ptr_ff),
      .wr_data({req_stamp, req_receipt_time}),
      .rd_en  (rd_en),
      .rd_addr(rd_addr_ff),
      .rd_data(rd_data)
   );

   assign ent_stamp = rd_data[ENTRY_WIDTH-1:TIME_WIDTH];
   assign ent_time  = rd_data[TIME_WIDTH-1:0];
   // top bit is the borrow: set when the entry is later than the query
   assign diff      = {1'b0, when_ff} - {1'b0, ent_time};
   assign hit       = pend_ff && (ent_stamp == key_ff) && !diff[TIME_WIDTH];

   always_comb begin
      state_in   = state_ff;
      wr_ptr_in  = wr_ptr_ff;
      fill_in    = fill_ff;
      rd_addr_in = rd_addr_ff;
      left_in    = left_ff;
      pend_in    = 1'b0;
      key_in     = key_ff;
      when_in    = when_ff;
      found_in   = found_ff;
      delay_in   = delay_ff;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               unique case (req_command)
                  CMD_ADD: begin
                     wr_ptr_in = (wr_ptr_ff == LAST_ADDR) ? '0 : wr_ptr_ff + 1'b1;
                     if (fill_ff != FULL_COUNT) begin
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  CMD_LOOKUP: begin
                     key_in     = req_stamp;
                     when_in    = req_receipt_time;
                     rd_addr_in = (wr_ptr_ff == '0) ? LAST_ADDR : wr_ptr_ff - 1'b1;
                     left_in    = fill_ff;
                     state_in   = SCAN;
                  end
                  default: ;
               endcase
            end
         end
         SCAN: begin
            if (left_ff != '0) begin
               pend_in    = 1'b1;
               left_in    = left_ff - 1'b1;
               rd_addr_in = (rd_addr_ff == '0) ? LAST_ADDR : rd_addr_ff - 1'b1;
            end
            priority if (hit) begin
               found_in = 1'b1;
               delay_in = diff[TIME_WIDTH-1:0];
               pend_in  = 1'b0;
               state_in = RESP;
            end else if (left_ff == '0) begin
               found_in = 1'b0;
               delay_in = '0;
               state_in = RESP;
            end else begin
            end
         end
         RESP: begin
            if (rsp_ready) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
         left_ff   <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
         left_ff   <= left_in;
         pend_ff   <= pend_in;
      end
      rd_addr_ff <= rd_addr_in;
      key_ff     <= key_in;
      when_ff    <= when_in;
      found_ff   <= found_in;
      delay_ff   <= delay_in;
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = (state_ff == RESP);
   assign rsp_found = found_ff;
   assign rsp_delay = delay_ff;

endmodule

### design/srhm_checker.sv
module srhm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 req_command,
   input logic signed [srhm_pkg::STAMP_WIDTH-1:0] req_stamp,
   input logic [srhm_pkg::TIME_WIDTH-1:0]      req_receipt_time,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_found,
   input logic [srhm_pkg::TIME_WIDTH-1:0]      rsp_delay
);
   import srhm_pkg::*;

   // an add word never produces a result word
   a_add_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_ADD) |=> !rsp_valid)
      else $error("result word after add");

   // a lookup keeps the block busy
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_LOOKUP) |=> !req_ready)
      else $error("ready right after lookup");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_delay == '0))
      else $error("nonzero delay on miss");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_delay))
      else $error("result word dropped or changed while stalled");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_command) &&
      $stable(req_stamp) && $stable(req_receipt_time))
      else $error("request word dropped or changed while waiting");

endmodule

bind stamp_receipt_history_match_unit srhm_checker u_srhm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_command     (req_command),
   .req_stamp       (req_stamp),
   .req_receipt_time(req_receipt_time),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_found       (rsp_found),
   .rsp_delay       (rsp_delay)
);
